/* hdl/door_code_lock_controller_core_assert.svh */
// assertion macros used by the checker file of the door code lock core
// no dependencies
`ifndef DOOR_CODE_LOCK_CONTROLLER_CORE_ASSERT_SVH
`define DOOR_CODE_LOCK_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DCLC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dclc assertion failed");

// next-cycle implication, checked outside reset
`define DCLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dclc assertion failed");

`endif

/* hdl/dclc_pkg.sv */
// types and codes of the door code lock core
// no dependencies
`default_nettype none

package dclc_pkg;

  localparam int ENTRY_W = 40;
  localparam int TICK_W  = 16;
  localparam int TRY_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int OUT_DAT_W = 16;

  typedef enum logic [1:0] {
    CMD_ENTRY  = 2'd0,
    CMD_OPEN   = 2'd1,
    CMD_CHANGE = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RPL_ACCEPTED = 2'd0,
    RPL_MATCH    = 2'd1,
    RPL_MISMATCH = 2'd2,
    RPL_IGNORED  = 2'd3
  } reply_t;

  typedef enum logic [3:0] {
    PH_SET_FIRST   = 4'd0,
    PH_SET_CONFIRM = 4'd1,
    PH_IDLE        = 4'd2,
    PH_VERIFY_OPEN = 4'd3,
    PH_VERIFY_CHG  = 4'd4,
    PH_TURNING     = 4'd5,
    PH_HOLDING     = 4'd6,
    PH_CLOSING     = 4'd7,
    PH_ALARM       = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    MOTOR_OFF = 2'd0,
    MOTOR_CW  = 2'd1,
    MOTOR_CCW = 2'd2
  } motor_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_WRONG = 2'd0,
    CFG_TURN      = 2'd1,
    CFG_HOLD      = 2'd2,
    CFG_ALARM     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [TRY_W-1:0]  max_wrong;
    logic [TICK_W-1:0] turn_ticks;
    logic [TICK_W-1:0] hold_ticks;
    logic [TICK_W-1:0] alarm_ticks;
  } cfg_regs_t;

  typedef struct packed {
    phase_t            phase;
    logic [TRY_W-1:0]  wrong_cnt;
    logic [TICK_W-1:0] tick_cnt;
  } lock_state_t;

  typedef struct packed {
    logic alarm_on;
    motor_t motor;
    phase_t phase;
    reply_t reply;
  } lock_result_t;

  typedef struct packed {
    logic first_ld;
    logic stored_ld;
  } code_ld_t;

endpackage

`default_nettype wire

/* hdl/dclc_cfg.sv */
// configuration registers of the door code lock core
// depends on dclc_pkg
`default_nettype none

module dclc_cfg
  import dclc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_idx,
  input  wire logic [CFG_DAT_W-1:0] wr_data,
  output cfg_regs_t                 regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      case (cfg_idx_t'(wr_idx))
        CFG_MAX_WRONG: regs_nxt.max_wrong   = wr_data[TRY_W-1:0];
        CFG_TURN:      regs_nxt.turn_ticks  = wr_data[TICK_W-1:0];
        CFG_HOLD:      regs_nxt.hold_ticks  = wr_data[TICK_W-1:0];
        CFG_ALARM:     regs_nxt.alarm_ticks = wr_data[TICK_W-1:0];
        default:       regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.max_wrong   <= TRY_W'(3);
      regs_r.turn_ticks  <= TICK_W'(2);
      regs_r.hold_ticks  <= TICK_W'(1);
      regs_r.alarm_ticks <= TICK_W'(8);
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

`default_nettype wire

/* hdl/dclc_step.sv */
// next-state and result logic of the door code lock core for one event
// depends on dclc_pkg
`default_nettype none

module dclc_step
  import dclc_pkg::*;
#(
  parameter int CMP_W = 40
) (
  input  wire cmd_t             cmd,
  input  wire logic [CMP_W-1:0] code,
  input  wire logic [CMP_W-1:0] first_code,
  input  wire logic [CMP_W-1:0] stored_code,
  input  wire lock_state_t      cur,
  input  wire cfg_regs_t        cfg,
  output lock_state_t           nxt,
  output lock_result_t          res,
  output code_ld_t              ld
);

  logic [TICK_W-1:0] tick_inc;
  logic [TICK_W-1:0] tick_lim;
  logic              tick_end;
  logic [TRY_W-1:0]  wrong_inc;
  phase_t            tick_next_phase;

  assign tick_inc  = cur.tick_cnt + TICK_W'(1);
  assign wrong_inc = cur.wrong_cnt + TRY_W'(1);

  always_comb begin
    case (cur.phase)
      PH_TURNING: begin
        tick_lim = cfg.turn_ticks;
        tick_next_phase = PH_HOLDING;
      end
      PH_HOLDING: begin
        tick_lim = cfg.hold_ticks;
        tick_next_phase = PH_CLOSING;
      end
      PH_CLOSING: begin
        tick_lim = cfg.turn_ticks;
        tick_next_phase = PH_IDLE;
      end
      default: begin
        tick_lim = cfg.alarm_ticks;
        tick_next_phase = PH_IDLE;
      end
    endcase
  end

  assign tick_end = (tick_inc >= tick_lim);

  always_comb begin
    nxt = cur;
    res.reply = RPL_IGNORED;
    ld = '0;
    case (cur.phase)
      PH_SET_FIRST: begin
        if (cmd == CMD_ENTRY) begin
          ld.first_ld = 1'b1;
          nxt.phase = PH_SET_CONFIRM;
          res.reply = RPL_ACCEPTED;
        end
      end
      PH_SET_CONFIRM: begin
        if (cmd == CMD_ENTRY) begin
          if (code == first_code) begin
            ld.stored_ld = 1'b1;
            nxt.phase = PH_IDLE;
            res.reply = RPL_MATCH;
          end else begin
            nxt.phase = PH_SET_FIRST;
            res.reply = RPL_MISMATCH;
          end
        end
      end
      PH_VERIFY_OPEN, PH_VERIFY_CHG: begin
        if (cmd == CMD_ENTRY) begin
          if (code == stored_code) begin
            nxt.wrong_cnt = '0;
            nxt.tick_cnt = '0;
            nxt.phase = (cur.phase == PH_VERIFY_OPEN) ? PH_TURNING : PH_SET_FIRST;
            res.reply = RPL_MATCH;
          end else begin
            nxt.wrong_cnt = wrong_inc;
            if (wrong_inc >= cfg.max_wrong) begin
              nxt.wrong_cnt = '0;
              nxt.tick_cnt = '0;
              nxt.phase = PH_ALARM;
            end
            res.reply = RPL_MISMATCH;
          end
        end
      end
      PH_TURNING, PH_HOLDING, PH_CLOSING, PH_ALARM: begin
        if (cmd == CMD_TICK) begin
          res.reply = RPL_ACCEPTED;
          if (tick_end) begin
            nxt.tick_cnt = '0;
            nxt.phase = tick_next_phase;
          end else begin
            nxt.tick_cnt = tick_inc;
          end
        end
      end
      default: begin
        if (cmd == CMD_OPEN) begin
          nxt.phase = PH_VERIFY_OPEN;
          res.reply = RPL_ACCEPTED;
        end else if (cmd == CMD_CHANGE) begin
          nxt.phase = PH_VERIFY_CHG;
          res.reply = RPL_ACCEPTED;
        end
      end
    endcase

    res.phase = nxt.phase;
    case (nxt.phase)
      PH_TURNING: res.motor = MOTOR_CW;
      PH_CLOSING: res.motor = MOTOR_CCW;
      default:    res.motor = MOTOR_OFF;
    endcase
    res.alarm_on = (nxt.phase == PH_ALARM);
  end

endmodule

`default_nettype wire

/* hdl/door_code_lock_controller_core.sv */
// Door code lock controller. Each input transfer is one event (code entry, open request,
// change request or timer tick) and yields exactly one result transfer with the verdict,
// the new phase, the motor drive and the alarm flag. An event is registered on entry and
// handled when the result register is free, where the phase, counters and codes update and
// the result is registered; a new event is taken every cycle, so throughput is one event per
// cycle, limited only by output back-pressure. Only the low 8*CODE_DIGITS bits of an entry
// (at most 40) are compared and stored. Configuration writes are taken at any time but
// belong in idle periods.
// depends on dclc_pkg, dclc_cfg and dclc_step
`default_nettype none

module door_code_lock_controller_core
  import dclc_pkg::*;
#(
  parameter int CODE_DIGITS = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [ENTRY_W-1:0]   in_tdata,   // entry_code
  input  wire logic [1:0]           in_tuser,   // command
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [OUT_DAT_W-1:0]      out_tdata,  // reply, phase, motor_drive, alarm_on, zero pad
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int CMP_W = (8 * CODE_DIGITS < ENTRY_W) ? 8 * CODE_DIGITS : ENTRY_W;

  logic              in_vld_r;
  cmd_t              in_cmd_r;
  logic [CMP_W-1:0]  in_code_r;
  logic              out_vld_r;
  lock_result_t      out_res_r;
  lock_state_t       state_r;
  logic [CMP_W-1:0]  first_r;
  logic [CMP_W-1:0]  stored_r;

  lock_state_t       state_nxt;
  lock_result_t      res_nxt;
  code_ld_t          ld;
  cfg_regs_t         cfg;
  logic              step_en;
  logic              in_xfer;

  assign cfg_ready = 1'b1;

  dclc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid & cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .regs    (cfg)
  );

  dclc_step #(
    .CMP_W (CMP_W)
  ) u_step (
    .cmd         (in_cmd_r),
    .code        (in_code_r),
    .first_code  (first_r),
    .stored_code (stored_r),
    .cur         (state_r),
    .cfg         (cfg),
    .nxt         (state_nxt),
    .res         (res_nxt),
    .ld          (ld)
  );

  assign step_en   = in_vld_r & (~out_vld_r | out_tready);
  assign in_tready = ~in_vld_r | step_en;
  assign in_xfer   = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r.phase     <= PH_SET_FIRST;
      state_r.wrong_cnt <= '0;
      state_r.tick_cnt  <= '0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (step_en) begin
        out_vld_r <= 1'b1;
        state_r   <= state_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_cmd_r  <= cmd_t'(in_tuser);
      in_code_r <= in_tdata[CMP_W-1:0];
    end
    if (step_en) begin
      out_res_r <= res_nxt;
      if (ld.first_ld) begin
        first_r <= in_code_r;
      end
      if (ld.stored_ld) begin
        stored_r <= in_code_r;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OUT_DAT_W - $bits(lock_result_t))'(0), out_res_r};

endmodule

`default_nettype wire

/* hdl/dclc_checker.sv */
// port-level checks of the door code lock core, bound to the top level
// depends on dclc_pkg and door_code_lock_controller_core_assert.svh
`default_nettype none

`include "door_code_lock_controller_core_assert.svh"

module dclc_checker
  import dclc_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_tvalid,
  input wire logic                 out_tready,
  input wire logic [OUT_DAT_W-1:0] out_tdata
);

  lock_result_t res;
  logic         stall;
  logic         motor_ok;
  logic         alarm_ok;
  logic         match_ok;
  logic         mismatch_ok;
  logic         is_match;
  logic         is_mismatch;

  assign res = lock_result_t'(out_tdata[$bits(lock_result_t)-1:0]);

  assign stall = out_tvalid && !out_tready;
  assign motor_ok = ((res.motor == MOTOR_CW) == (res.phase == PH_TURNING)) &&
                    ((res.motor == MOTOR_CCW) == (res.phase == PH_CLOSING));
  assign alarm_ok = (res.alarm_on == (res.phase == PH_ALARM));
  assign match_ok = res.phase inside {PH_SET_FIRST, PH_IDLE, PH_TURNING};
  assign mismatch_ok = res.phase inside {PH_SET_FIRST, PH_VERIFY_OPEN, PH_VERIFY_CHG, PH_ALARM};
  assign is_match = out_tvalid && (res.reply == RPL_MATCH);
  assign is_mismatch = out_tvalid && (res.reply == RPL_MISMATCH);

  `DCLC_ASSERT_NEXT(a_out_hold, clk, rst_n, stall, out_tvalid && $stable(out_tdata))
  `DCLC_ASSERT_IMPLY(a_motor_phase, clk, rst_n, out_tvalid, motor_ok)
  `DCLC_ASSERT_IMPLY(a_alarm_phase, clk, rst_n, out_tvalid, alarm_ok)
  `DCLC_ASSERT_IMPLY(a_match_phase, clk, rst_n, is_match, match_ok)
  `DCLC_ASSERT_IMPLY(a_mismatch_phase, clk, rst_n, is_mismatch, mismatch_ok)

endmodule

bind door_code_lock_controller_core dclc_checker u_dclc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
